// ===== hdl/point_store_radius_nearest_search_unit_assert.svh =====
// Assertion helpers for the point store search unit.
// Each macro expects clk and rst to be visible where it is used.
`ifndef POINT_STORE_RADIUS_NEAREST_SEARCH_UNIT_ASSERT_SVH
`define POINT_STORE_RADIUS_NEAREST_SEARCH_UNIT_ASSERT_SVH

// Condition that must hold at every edge out of reset.
`define PSRNS_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold after the antecedent, as a non-overlapping implication.
`define PSRNS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/psrns_pkg.sv =====
`default_nettype none

package psrns_pkg;

  // Table size and derived widths
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Coordinate and distance widths
  localparam int COORD_W = 16;
  localparam int ABS_W   = 16;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int DIST_W  = SQ_W + 1;
  localparam int RAD_W   = 15;
  localparam int R2_W    = 2 * RAD_W;
  localparam int ENTRY_W = 2 * COORD_W;

  // Request codes
  localparam logic [2:0] REQ_CLEAR   = 3'd0;
  localparam logic [2:0] REQ_INSERT  = 3'd1;
  localparam logic [2:0] REQ_UPDATE  = 3'd2;
  localparam logic [2:0] REQ_RADIUS  = 3'd3;
  localparam logic [2:0] REQ_NEAREST = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam int HIT_MAX = 127;

  typedef struct packed {
    logic [2:0]                req_type;
    logic [5:0]                point_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [RAD_W-1:0]          radius;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] index_out;
    logic [6:0] hit_count;
    logic       any_found;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/psrns_ram.sv =====
`default_nettype none

module psrns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output      logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/point_store_radius_nearest_search_unit.sv =====
// Clear, insert, update and unused codes go from S_DECODE to S_DONE, which registers the
// result; so do radius count with zero radius or empty table and nearest search on an
// empty table. Else radius count adds S_SQ, S_R2, S_SCAN, S_DRAIN; nearest adds S_SCAN,
// S_DRAIN. One squared-distance unit scans one stored point per cycle from the table RAM.
// Throughput: one request in flight; the next beat is taken once the result is registered.
// Reset clears the point count, the sequencer and out_valid; table contents stay undefined.
`default_nettype none

module point_store_radius_nearest_search_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire psrns_pkg::req_t  in_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      psrns_pkg::rsp_t  out_data
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_SQ     = 7'b0000100,
    S_R2     = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  psrns_pkg::req_t                     req;
  logic [psrns_pkg::CNT_W-1:0]         stored_count;
  logic [psrns_pkg::CNT_W-1:0]         scan_ptr;
  logic [psrns_pkg::R2_W-1:0]          r2;

  // Result being built
  logic [1:0]                          res_status;
  logic [5:0]                          res_index;
  logic [psrns_pkg::CNT_W-1:0]         hits;
  logic [psrns_pkg::IDX_W-1:0]         best_idx;
  logic [psrns_pkg::DIST_W-1:0]        best_dist;
  logic                                is_nearest;

  // Distance pipeline
  logic                                rv, av, sv;
  logic [psrns_pkg::IDX_W-1:0]         rtag, atag, stag;
  logic [psrns_pkg::ABS_W-1:0]         ax, ay;
  logic [psrns_pkg::SQ_W-1:0]          sqx, sqy;

  // RAM ports
  logic                                ram_we;
  logic [psrns_pkg::IDX_W-1:0]         ram_waddr;
  logic                                ram_re;
  logic [psrns_pkg::ENTRY_W-1:0]       ram_rdata;

  logic                                accept;
  logic                                insert_ok;
  logic                                update_ok;
  logic                                out_free;
  logic signed [psrns_pkg::COORD_W:0]  dx, dy;
  logic [psrns_pkg::DIST_W-1:0]        dist_sum;
  logic [6:0]                          hit_sat;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign insert_ok = (stored_count < psrns_pkg::CNT_W'(psrns_pkg::MAX_POINTS));
  assign update_ok = (psrns_pkg::CNT_W'(req.point_index) < stored_count) &&
                     (32'(req.point_index) < psrns_pkg::MAX_POINTS);

  // Table write in the decode cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = stored_count[psrns_pkg::IDX_W-1:0];
    if (state == S_DECODE) begin
      case (req.req_type)
        psrns_pkg::REQ_INSERT: begin
          ram_we = insert_ok;
        end
        psrns_pkg::REQ_UPDATE: begin
          ram_we    = update_ok;
          ram_waddr = req.point_index[psrns_pkg::IDX_W-1:0];
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  assign ram_re = (state == S_SCAN);

  psrns_ram #(
    .WIDTH (psrns_pkg::ENTRY_W),
    .DEPTH (psrns_pkg::MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({req.pos_x, req.pos_y}),
    .re    (ram_re),
    .raddr (scan_ptr[psrns_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Offsets from the query origin
  always_comb begin
    dx = $signed({ram_rdata[psrns_pkg::ENTRY_W-1], ram_rdata[psrns_pkg::ENTRY_W-1 -: 16]}) -
         $signed({req.pos_x[psrns_pkg::COORD_W-1], req.pos_x});
    dy = $signed({ram_rdata[psrns_pkg::COORD_W-1], ram_rdata[psrns_pkg::COORD_W-1:0]}) -
         $signed({req.pos_y[psrns_pkg::COORD_W-1], req.pos_y});
  end

  assign dist_sum = psrns_pkg::DIST_W'(sqx) + psrns_pkg::DIST_W'(sqy);

  // Advance the squared-distance pipeline; the decode cycle loads the radius for squaring
  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      ax <= psrns_pkg::ABS_W'(req.radius);
      ay <= '0;
    end else begin
      ax <= dx[psrns_pkg::COORD_W] ? psrns_pkg::ABS_W'(-dx) : psrns_pkg::ABS_W'(dx);
      ay <= dy[psrns_pkg::COORD_W] ? psrns_pkg::ABS_W'(-dy) : psrns_pkg::ABS_W'(dy);
    end
    sqx  <= ax * ax;
    sqy  <= ay * ay;
    rtag <= scan_ptr[psrns_pkg::IDX_W-1:0];
    atag <= rtag;
    stag <= atag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
      av <= 1'b0;
      sv <= 1'b0;
    end else begin
      rv <= ram_re;
      av <= rv;
      sv <= av;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Raise out_valid as the result loads, drop it once the beat is taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (req.req_type)
            psrns_pkg::REQ_CLEAR: begin
              stored_count <= '0;
              state        <= S_DONE;
            end
            psrns_pkg::REQ_INSERT: begin
              if (insert_ok) begin
                stored_count <= stored_count + 1'b1;
              end
              state <= S_DONE;
            end
            psrns_pkg::REQ_RADIUS: begin
              if (req.radius == '0 || stored_count == '0) begin
                state <= S_DONE;
              end else begin
                state <= S_SQ;
              end
            end
            psrns_pkg::REQ_NEAREST: begin
              if (stored_count == '0) begin
                state <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_SQ: begin
          state <= S_R2;
        end
        S_R2: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_ptr + 1'b1 >= stored_count) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rv && !av && !sv) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the request and build the result
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
    end
    if (state == S_R2) begin
      r2 <= sqx[psrns_pkg::R2_W-1:0];
    end
    if (state == S_SCAN) begin
      scan_ptr <= scan_ptr + 1'b1;
    end
    if (state == S_DECODE) begin
      scan_ptr   <= '0;
      hits       <= '0;
      best_idx   <= '0;
      best_dist  <= '0;
      is_nearest <= (req.req_type == psrns_pkg::REQ_NEAREST);
      case (req.req_type)
        psrns_pkg::REQ_INSERT: begin
          res_status <= insert_ok ? psrns_pkg::ST_OK : psrns_pkg::ST_FULL;
          res_index  <= insert_ok ? 6'(stored_count) : 6'd0;
        end
        psrns_pkg::REQ_UPDATE: begin
          res_status <= update_ok ? psrns_pkg::ST_OK : psrns_pkg::ST_BAD_INDEX;
          res_index  <= '0;
        end
        psrns_pkg::REQ_NEAREST: begin
          res_status <= (stored_count == '0) ? psrns_pkg::ST_EMPTY : psrns_pkg::ST_OK;
          res_index  <= '0;
        end
        default: begin
          res_status <= psrns_pkg::ST_OK;
          res_index  <= '0;
        end
      endcase
    end else if (sv) begin
      // Accumulate one distance per cycle
      if (is_nearest) begin
        if (stag == '0 || dist_sum < best_dist) begin
          best_dist <= dist_sum;
          best_idx  <= stag;
        end
      end else if (dist_sum <= psrns_pkg::DIST_W'(r2)) begin
        hits <= hits + 1'b1;
      end
    end
  end

  assign hit_sat = (32'(hits) > psrns_pkg::HIT_MAX) ? 7'(psrns_pkg::HIT_MAX) : 7'(hits);

  // Load the output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data.status    <= res_status;
      out_data.index_out <= is_nearest ? 6'(best_idx) : res_index;
      out_data.hit_count <= is_nearest ? 7'd0 : hit_sat;
      out_data.any_found <= !is_nearest && (hits != '0);
    end
  end

  `include "point_store_radius_nearest_search_unit_assert.svh"

  `PSRNS_ALWAYS(a_count_range, stored_count <= psrns_pkg::CNT_W'(psrns_pkg::MAX_POINTS), "point count exceeds table size")
  `PSRNS_ALWAYS(a_idle_pipe_empty, !in_ready || (!rv && !av && !sv), "request taken while scan pipeline busy")
  `PSRNS_ALWAYS(a_scan_bound, state != S_SCAN || scan_ptr < stored_count, "scan pointer past stored points")
  `PSRNS_NEXT(a_result_load, state == S_DONE && out_free, out_valid && state == S_IDLE, "result not registered")
  `PSRNS_NEXT(a_insert_count, state == S_DECODE && req.req_type == psrns_pkg::REQ_INSERT && insert_ok, stored_count == psrns_pkg::CNT_W'($past(stored_count) + 1'b1), "insert did not grow the table")

endmodule

`default_nettype wire
